// File: hw/rtl/bpsaj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot PROM shadow and auto-start jam: shared package
// Bus cycle kinds, register indexes, fixed byte values and the structs that
// pass between the control, PROM and top-level modules.
// ----------------------------------------------------------------------------
package bpsaj_pkg;

  // Boot PROM size and derived widths
  localparam int unsigned PROM_BYTES = 1024;
  localparam int unsigned PROM_AW    = $clog2(PROM_BYTES);
  localparam int unsigned CLR_CW     = PROM_AW + 1;
  localparam logic [16:0] PROM_SPAN  = 17'(PROM_BYTES);

  // Fixed byte values
  localparam logic [7:0] JAM_OP_JMP    = 8'hC3;
  localparam logic [7:0] JAM_LOW_BYTE  = 8'h00;
  localparam logic [7:0] PORT_PROM_OFF = 8'hFE;
  localparam logic [7:0] PORT_SENSE    = 8'hFF;
  localparam logic [7:0] RD_IDLE       = 8'hFF;
  localparam logic [7:0] PROM_ERASED   = 8'hFF;
  localparam logic [1:0] JAM_STEPS     = 2'd3;

  // Bus cycle kinds
  typedef enum logic [2:0] {
    KIND_MEM_RD    = 3'd0,
    KIND_MEM_WR    = 3'd1,
    KIND_IO_RD     = 3'd2,
    KIND_IO_WR     = 3'd3,
    KIND_SYS_RESET = 3'd4,
    KIND_PROM_LOAD = 3'd5
  } kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CARD_ENABLE = 3'd0,
    CFG_PROM_BASE   = 3'd1,
    CFG_START_PAGE  = 3'd2,
    CFG_SENSE_SW    = 3'd3,
    CFG_SERIAL_BASE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        card_enable;
    logic [15:0] prom_base;
    logic [7:0]  start_page;
    logic [7:0]  sense_sw;
    logic [7:0]  serial_base;
  } cfg_t;

  // Decoded result of one bus cycle; PROM byte is merged in later
  typedef struct packed {
    logic       claimed;
    logic       phantom;
    logic [7:0] read_data;
    logic       use_prom;
    logic       serial_access;
    logic       decode_changed;
  } res_t;

  typedef struct packed {
    logic               wr_en;
    logic [PROM_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [PROM_AW-1:0] rd_addr;
  } prom_req_t;

endpackage

// File: hw/rtl/bpsaj_prom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot PROM store
// Single-port-write, registered-read byte memory. After reset a sweep writes
// the erased value to every entry; busy_o is high until the sweep ends.
// ----------------------------------------------------------------------------
module bpsaj_prom import bpsaj_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  prom_req_t req_i,
  output logic [7:0] rd_data_o,
  output logic      busy_o
);

  logic [7:0]        mem_q [PROM_BYTES];
  logic [7:0]        rd_data_q;
  logic [CLR_CW-1:0] clr_cnt_q;
  logic [CLR_CW-1:0] clr_cnt_d;

  assign busy_o    = (clr_cnt_q != CLR_CW'(PROM_BYTES));
  assign clr_cnt_d = busy_o ? clr_cnt_q + CLR_CW'(1) : clr_cnt_q;

  // Erase sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Storage: sweep has the write port until done, then byte loads
  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      mem_q[clr_cnt_q[PROM_AW-1:0]] <= PROM_ERASED;
    end else if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/bpsaj_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus cycle decode and latch control
// Decodes one bus word against the jam, PROM window, sense switch and serial
// ports, updates the jam and PROM latches and registers the result.
// ----------------------------------------------------------------------------
module bpsaj_ctrl import bpsaj_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [2:0] kind_i,
  input  logic [15:0] address_i,
  input  logic [7:0] write_data_i,
  input  cfg_t       cfg_i,
  output prom_req_t  prom_req_o,
  output res_t       res_o
);

  kind_e       kind;
  logic [7:0]  port;
  logic [16:0] addr_x;
  logic [16:0] base_x;
  logic [16:0] offset;
  logic        in_win;
  logic        win;
  logic        jam_hit;
  logic [1:0]  step_inc;
  logic        decodes;
  logic        is_serial;

  logic       prom_armed_q, prom_armed_d;
  logic       jam_armed_q, jam_armed_d;
  logic [1:0] jam_step_q, jam_step_d;
  res_t       res_q, res_d;

  assign kind     = kind_e'(kind_i);
  assign port     = address_i[7:0];
  assign addr_x   = {1'b0, address_i};
  assign base_x   = {1'b0, cfg_i.prom_base};
  assign offset   = addr_x - base_x;
  // Window stops at the top of memory, no wrap
  assign in_win   = (addr_x >= base_x) && (addr_x < base_x + PROM_SPAN);
  assign win      = prom_armed_q && in_win;
  assign jam_hit  = (kind == KIND_MEM_RD) && jam_armed_q && (jam_step_q < JAM_STEPS) &&
                    (address_i == {14'b0, jam_step_q});
  assign step_inc = jam_step_q + 2'd1;
  // Serial pair is base and base+1; base+1 is compared on 9 bits, so base FF does not wrap to port 00
  assign is_serial = ({1'b0, port} == {1'b0, cfg_i.serial_base}) ||
                     ({1'b0, port} == {1'b0, cfg_i.serial_base} + 9'd1);

  // Decode and next latch state
  always_comb begin
    decodes              = 1'b0;
    res_d.phantom        = 1'b0;
    res_d.read_data      = RD_IDLE;
    res_d.use_prom       = 1'b0;
    res_d.serial_access  = 1'b0;
    res_d.decode_changed = 1'b0;
    prom_armed_d         = prom_armed_q;
    jam_armed_d          = jam_armed_q;
    jam_step_d           = jam_step_q;

    case (kind)
      KIND_MEM_RD: begin
        if (jam_hit) begin
          decodes       = 1'b1;
          res_d.phantom = 1'b1;
          case (jam_step_q)
            2'd0:    res_d.read_data = JAM_OP_JMP;
            2'd1:    res_d.read_data = JAM_LOW_BYTE;
            default: res_d.read_data = cfg_i.start_page;
          endcase
        end else if (win) begin
          decodes        = 1'b1;
          res_d.phantom  = 1'b1;
          res_d.use_prom = 1'b1;
        end
      end
      KIND_MEM_WR: begin
        res_d.phantom = win;
      end
      KIND_IO_RD, KIND_IO_WR: begin
        res_d.serial_access = is_serial;
        decodes             = is_serial;
        if (kind == KIND_IO_RD && port == PORT_SENSE) begin
          decodes         = 1'b1;
          res_d.read_data = cfg_i.sense_sw;
        end
      end
      KIND_SYS_RESET: begin
        res_d.decode_changed = !prom_armed_q || !jam_armed_q || (jam_step_q != 2'd0);
        prom_armed_d         = 1'b1;
        jam_armed_d          = 1'b1;
        jam_step_d           = 2'd0;
      end
      KIND_PROM_LOAD: begin
        // store write only, see PROM request
      end
      default: begin
      end
    endcase

    // Jam sequencing: third read ends the jam
    if (jam_hit) begin
      jam_step_d = step_inc;
      if (step_inc == JAM_STEPS) begin
        jam_armed_d          = 1'b0;
        res_d.decode_changed = 1'b1;
      end
    end

    // First read of port FE or FF switches the PROM out
    if (prom_armed_q && kind == KIND_IO_RD && (port == PORT_PROM_OFF || port == PORT_SENSE)) begin
      prom_armed_d         = 1'b0;
      res_d.decode_changed = 1'b1;
    end

    res_d.claimed = decodes && cfg_i.card_enable;
  end

  // PROM access for this word
  always_comb begin
    prom_req_o.wr_en   = accept_i && (kind == KIND_PROM_LOAD) && (addr_x < PROM_SPAN);
    prom_req_o.wr_addr = address_i[PROM_AW-1:0];
    prom_req_o.wr_data = write_data_i;
    prom_req_o.rd_en   = accept_i && (kind == KIND_MEM_RD);
    prom_req_o.rd_addr = offset[PROM_AW-1:0];
  end

  // Latches
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prom_armed_q <= 1'b1;
      jam_armed_q  <= 1'b1;
      jam_step_q   <= 2'd0;
    end else if (accept_i) begin
      prom_armed_q <= prom_armed_d;
      jam_armed_q  <= jam_armed_d;
      jam_step_q   <= jam_step_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// File: hw/rtl/boot_prom_shadow_and_autostart_jam_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot PROM shadow and auto-start jam unit
// Snoops one processor bus cycle per input word and reports how the boot
// card answers it: claim, phantom, read byte, serial flag, decode change.
//
// Input channel: in_valid_i / in_stall_o with kind, address and write data.
// Output channel: out_valid_o / out_stall_i with one result word per input.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at once.
// An accepted word is registered in the decode stage, then moves into the
// output register, which raises out_valid_o; a new word can be taken every
// cycle while in_stall_o is low. A decode stage and an output register
// part the sides, so one word is still taken while a result waits on a
// stalled receiver; when both hold words, in_stall_o rises until the
// receiver takes one. After reset the PROM is erased by a sweep over all
// 1024 bytes (one byte per cycle through its single write port); in_stall_o
// is high meanwhile, while configuration writes are taken as normal. Reset
// arms the jam and PROM latches and loads the register defaults.
// ----------------------------------------------------------------------------
module boot_prom_shadow_and_autostart_jam_unit import bpsaj_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // bus cycle in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  // result out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        claimed_o,
  output logic        phantom_o,
  output logic [7:0]  read_data_o,
  output logic        serial_access_o,
  output logic        decode_changed_o
);

  cfg_t      cfg_q;
  prom_req_t prom_req;
  res_t      res;
  logic [7:0] prom_rd;
  logic      prom_busy;
  logic      accept;
  logic      s1_valid_q, s1_valid_d;
  logic      s1_adv;
  logic      out_valid_q;
  logic      claimed_q, phantom_q, serial_q, changed_q;
  logic [7:0] read_data_q, read_data_d;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.card_enable <= 1'b1;
      cfg_q.prom_base   <= 16'hFC00;
      cfg_q.start_page  <= 8'h00;
      cfg_q.sense_sw    <= 8'h00;
      cfg_q.serial_base <= 8'h10;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CARD_ENABLE: cfg_q.card_enable <= cfg_wdata_i[0];
        CFG_PROM_BASE:   cfg_q.prom_base   <= cfg_wdata_i;
        CFG_START_PAGE:  cfg_q.start_page  <= cfg_wdata_i[7:0];
        CFG_SENSE_SW:    cfg_q.sense_sw    <= cfg_wdata_i[7:0];
        CFG_SERIAL_BASE: cfg_q.serial_base <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: decode stage moves on when the output register is free
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = prom_busy || (s1_valid_q && !s1_adv);
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_valid_d = accept || (s1_valid_q && !s1_adv);

  bpsaj_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .cfg_i        (cfg_q),
    .prom_req_o   (prom_req),
    .res_o        (res)
  );

  bpsaj_prom u_prom (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (prom_req),
    .rd_data_o (prom_rd),
    .busy_o    (prom_busy)
  );

  // PROM byte replaces the default for window reads
  assign read_data_d = res.use_prom ? prom_rd : res.read_data;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      claimed_q   <= res.claimed;
      phantom_q   <= res.phantom;
      read_data_q <= read_data_d;
      serial_q    <= res.serial_access;
      changed_q   <= res.decode_changed;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign claimed_o        = claimed_q;
  assign phantom_o        = phantom_q;
  assign read_data_o      = read_data_q;
  assign serial_access_o  = serial_q;
  assign decode_changed_o = changed_q;

endmodule

// File: hw/rtl/bpsaj_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot PROM shadow and auto-start jam: port checker
// Watches the top-level ports for output hold, erase sweep stall and decode
// consistency; bound to the top level below.
// ----------------------------------------------------------------------------
module bpsaj_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       claimed_o,
  input logic       phantom_o,
  input logic [7:0] read_data_o,
  input logic       serial_access_o,
  input logic       decode_changed_o
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o) &&
      $stable(claimed_o) && $stable(phantom_o) && $stable(decode_changed_o))
    else $error("result word changed while stalled");

  // Input held off when reset is released and the PROM erase begins
  a_erase_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input taken during PROM erase");

  // Serial flag never with phantom: serial only on I/O words, phantom only on memory words
  a_serial_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && serial_access_o |-> !phantom_o)
    else $error("serial access with phantom");

endmodule

bind boot_prom_shadow_and_autostart_jam_unit bpsaj_checker u_bpsaj_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .claimed_o        (claimed_o),
  .phantom_o        (phantom_o),
  .read_data_o      (read_data_o),
  .serial_access_o  (serial_access_o),
  .decode_changed_o (decode_changed_o)
);
